// ===== sv/slt_pkg.sv =====
// Shared types and constants for the scan line lattice block.
// No dependencies.
`default_nettype none
package slt_pkg;
  localparam int LinesW   = 10;
  localparam int SamplesW = 20;
  localparam int LineW    = 12;

  localparam logic [LinesW-1:0]   LinesReset   = 10'd625;
  localparam logic [SamplesW-1:0] SamplesReset = 20'd709379;
  localparam logic [SamplesW-1:0] WholeReset   = 20'd1135;
  localparam logic [LinesW-1:0]   RemReset     = 10'd4;

  localparam logic RegLines   = 1'b0;
  localparam logic RegSamples = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } cfg_state_t;

  // frame settings and the nominal line length
  typedef struct packed {
    logic [LinesW-1:0]   lines;
    logic [SamplesW-1:0] samples;
    logic [SamplesW-1:0] whole;
    logic [LinesW-1:0]   rem;
    logic                busy;
  } lattice_t;
endpackage
`default_nettype wire

// ===== sv/slt_cfg.sv =====
// Frame registers and a bit-serial divider that forms samples / lines.
// Depends on slt_pkg.
`default_nettype none
module slt_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [slt_pkg::SamplesW-1:0]  cfg_data,
  output slt_pkg::lattice_t                  lat
);
  logic [slt_pkg::LinesW-1:0]   lines;
  logic [slt_pkg::SamplesW-1:0] samples;
  logic [slt_pkg::SamplesW-1:0] whole;
  logic [slt_pkg::LinesW-1:0]   rem;
  logic [slt_pkg::SamplesW-1:0] dividend;
  logic [4:0]                   count;
  slt_pkg::cfg_state_t          state;
  logic [slt_pkg::LinesW:0]     trial;
  logic                         fits;

  assign trial = {rem, dividend[slt_pkg::SamplesW-1]};
  assign fits  = trial >= {1'b0, lines};

  always_ff @(posedge clk) begin
    if (rst) begin
      lines   <= slt_pkg::LinesReset;
      samples <= slt_pkg::SamplesReset;
      whole   <= slt_pkg::WholeReset;
      rem     <= slt_pkg::RemReset;
      state   <= slt_pkg::ST_IDLE;
      count   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == slt_pkg::RegLines) begin
        lines    <= cfg_data[slt_pkg::LinesW-1:0];
        dividend <= samples;
      end else begin
        samples  <= cfg_data;
        dividend <= cfg_data;
      end
      whole <= '0;
      rem   <= '0;
      count <= '0;
      state <= slt_pkg::ST_DIV;
    end else begin
      case (state)
        slt_pkg::ST_IDLE: begin
        end
        slt_pkg::ST_DIV: begin
          if (lines == '0) begin
            // no lines: nominal fields stay zero
            state <= slt_pkg::ST_IDLE;
          end else begin
            dividend <= {dividend[slt_pkg::SamplesW-2:0], 1'b0};
            whole    <= {whole[slt_pkg::SamplesW-2:0], fits};
            rem      <= fits ? 10'(trial - {1'b0, lines}) : trial[slt_pkg::LinesW-1:0];
            count    <= count + 5'd1;
            if (count == 5'(slt_pkg::SamplesW - 1)) state <= slt_pkg::ST_IDLE;
          end
        end
        default: state <= slt_pkg::ST_IDLE;
      endcase
    end
  end

  assign lat = {lines, samples, whole, rem, (state != slt_pkg::ST_IDLE)};
endmodule
`default_nettype wire

// ===== sv/scan_line_lattice.sv =====
// Scan line lattice: start, length and phase of one line of a frame.
// Depends on slt_pkg and slt_cfg.
//
// Input channel: line_index with in_valid/in_ready. Output channel: six
// fields with out_valid/out_ready, one word out for each word in.
// Config: cfg_we writes the line count (index 0) or the sample count
// (index 1); each write starts a bit-serial divide of samples by
// lines (a single step when the line count is zero), during which in_ready is
// low. After reset the nominal length is preloaded and words are taken at once.
// From the accepting edge to out_valid a word passes 13 register
// stages: one multiply stage, one add stage, ten compare-subtract
// stages (one quotient bit each, for the fraction k*rem/lines of the line
// and of the next), and the output register. Throughput is one word per
// cycle while no divide runs. When out_valid is high and out_ready is low
// the whole pipeline holds and in_ready drops; nothing is lost or repeated.
`default_nettype none
module scan_line_lattice (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [slt_pkg::SamplesW-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [slt_pkg::LineW-1:0]     line_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [slt_pkg::SamplesW-1:0]       start_sample,
  output logic [slt_pkg::SamplesW-1:0]       length_samples,
  output logic [slt_pkg::LinesW-1:0]         phase_numerator,
  output logic [slt_pkg::SamplesW-1:0]       nominal_whole,
  output logic [slt_pkg::LinesW-1:0]         nominal_remainder,
  output logic                               orthogonal
);
  localparam int NDiv = slt_pkg::LinesW;
  localparam int LW   = slt_pkg::LinesW;
  localparam int SW   = slt_pkg::SamplesW;

  typedef struct packed {
    logic          inr;
    logic          last;
    logic          lz;
    logic [SW-1:0] kw;
  } side_t;

  slt_pkg::lattice_t lat;
  logic              adv;

  slt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lat       (lat)
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !lat.busy;

  // stage 0: products
  logic                v0;
  side_t               sd0;
  logic [SW-1:0]       p0;
  // stage 1: dividends for this line and the next
  logic                v1;
  side_t               sd1;
  logic [SW-1:0]       pa1, pb1;
  // divide stages
  logic                vd  [NDiv];
  side_t               sdd [NDiv];
  logic [LW-1:0]       ra  [NDiv], rb [NDiv];
  logic [LW-1:0]       qa  [NDiv], qb [NDiv];
  logic [LW-1:0]       la  [NDiv], lb [NDiv];

  logic [LW:0]         ta  [NDiv], tb [NDiv];
  logic [LW-1:0]       ria [NDiv], rib [NDiv];
  logic [LW-1:0]       qia [NDiv], qib [NDiv];
  logic [LW-1:0]       lia [NDiv], lib [NDiv];

  logic [LW-1:0]       k10;
  assign k10 = line_index[LW-1:0];

  always_comb begin
    ria[0] = pa1[SW-1:LW]; rib[0] = pb1[SW-1:LW];
    lia[0] = pa1[LW-1:0];  lib[0] = pb1[LW-1:0];
    qia[0] = '0;           qib[0] = '0;
    for (int j = 1; j < NDiv; j++) begin
      ria[j] = ra[j-1]; rib[j] = rb[j-1];
      lia[j] = la[j-1]; lib[j] = lb[j-1];
      qia[j] = qa[j-1]; qib[j] = qb[j-1];
    end
    for (int j = 0; j < NDiv; j++) begin
      ta[j] = {ria[j], lia[j][LW-1]};
      tb[j] = {rib[j], lib[j][LW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      for (int j = 0; j < NDiv; j++) vd[j] <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid && in_ready;
      v1 <= v0;
      vd[0] <= v1;
      for (int j = 1; j < NDiv; j++) vd[j] <= vd[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd0.inr  <= {2'b00, lat.lines} > line_index;
      sd0.last <= {2'b00, lat.lines} == line_index + 12'd1;
      sd0.lz   <= lat.lines == '0;
      sd0.kw   <= {10'd0, k10} * lat.whole;
      p0       <= {10'd0, k10} * {10'd0, lat.rem};
      sd1 <= sd0;
      pa1 <= p0;
      pb1 <= p0 + {10'd0, lat.rem};
      sdd[0] <= sd1;
      for (int j = 1; j < NDiv; j++) sdd[j] <= sdd[j-1];
      for (int j = 0; j < NDiv; j++) begin
        la[j]  <= {lia[j][LW-2:0], 1'b0};
        lb[j]  <= {lib[j][LW-2:0], 1'b0};
        if (ta[j] >= {1'b0, lat.lines}) begin
          ra[j] <= LW'(ta[j] - {1'b0, lat.lines});
          qa[j] <= {qia[j][LW-2:0], 1'b1};
        end else begin
          ra[j] <= ta[j][LW-1:0];
          qa[j] <= {qia[j][LW-2:0], 1'b0};
        end
        if (tb[j] >= {1'b0, lat.lines}) begin
          rb[j] <= LW'(tb[j] - {1'b0, lat.lines});
          qb[j] <= {qib[j][LW-2:0], 1'b1};
        end else begin
          rb[j] <= tb[j][LW-1:0];
          qb[j] <= {qib[j][LW-2:0], 1'b0};
        end
      end
    end
  end

  // output stage: ceil of the fraction, start, next start, phase
  side_t         sf;
  logic [LW-1:0] qf_a, qf_b, rf_a, rf_b;
  logic [SW-1:0] start_c, next_c;
  assign sf   = sdd[NDiv-1];
  assign qf_a = qa[NDiv-1];
  assign qf_b = qb[NDiv-1];
  assign rf_a = ra[NDiv-1];
  assign rf_b = rb[NDiv-1];
  assign start_c = sf.kw + {10'd0, qf_a} + {19'd0, (rf_a != '0)};
  assign next_c  = sf.last ? lat.samples
                 : sf.kw + lat.whole + {10'd0, qf_b} + {19'd0, (rf_b != '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vd[NDiv-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sf.lz) begin
        start_sample    <= '0;
        length_samples  <= '0;
        phase_numerator <= '0;
      end else if (!sf.inr) begin
        start_sample    <= lat.samples;
        length_samples  <= '0;
        phase_numerator <= '0;
      end else begin
        start_sample    <= start_c;
        length_samples  <= next_c - start_c;
        phase_numerator <= (rf_a != '0) ? lat.lines - rf_a : '0;
      end
      nominal_whole     <= lat.whole;
      nominal_remainder <= lat.rem;
      orthogonal        <= !sf.lz && (lat.rem == '0);
    end
  end
endmodule
`default_nettype wire
